[rtl/hsbe_pkg.sv]
// ----------------------------------------------------------------------------
// HTML script body extractor package
// Mode codes, character constants, pattern tables and the result entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package hsbe_pkg;

  // Most results one input byte can cause: '<', six held bytes, the byte
  // itself and an end marker
  localparam int unsigned RES_DEPTH = 9;
  // Depth of the held close-tag prefix
  localparam int unsigned HOLD_DEPTH = 6;
  // Bytes that can be emitted for one input (all but the end marker)
  localparam int unsigned SEQ_DEPTH = RES_DEPTH - 1;

  // Length of a pattern once it is fully matched
  localparam logic [2:0] OPEN_DONE  = 3'd7;
  // Index of the last character of "/script"
  localparam logic [2:0] CLOSE_LAST = 3'd6;

  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CH_BANG = 8'h21;  // '!'
  localparam logic [7:0] CH_NL   = 8'h0A;  // newline

  typedef enum logic [2:0] {
    MODE_SEARCH = 3'd0,  // look for "<script" or "<SCRIPT"
    MODE_OPEN   = 3'd1,  // skip to '>' of the opening tag
    MODE_BODY   = 3'd2,  // emit body bytes
    MODE_LT     = 3'd3,  // after '<' in a body, matching "/script"
    MODE_BANG   = 3'd4,  // drop up to newline
    MODE_CLOSE  = 3'd5   // skip to '>' of the closing tag
  } mode_t;

  typedef enum logic {
    KIND_BODY = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       first;
  } rslt_t;

  // "<script" by position
  function automatic logic [7:0] open_lo_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h70;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "<SCRIPT" by position
  function automatic logic [7:0] open_up_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h3C;
      3'd1:    c = 8'h53;
      3'd2:    c = 8'h43;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h49;
      3'd5:    c = 8'h50;
      3'd6:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "/script" by position
  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h2F;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h72;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h70;
      3'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Fold upper case ASCII letters to lower case
  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'd32;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // Advance a partial match of an opening tag by one byte
  function automatic logic [2:0] adv_open(input logic [2:0] m, input logic [7:0] pat_c,
                                          input logic [7:0] b);
    logic [2:0] r;
    if (m != OPEN_DONE && b == pat_c) begin
      r = m + 3'd1;
    end else if (b == CH_LT) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/html_script_body_extractor.sv]
// ----------------------------------------------------------------------------
// HTML script body extractor
// Passes on only the bytes inside script elements of an HTML byte stream.
// ----------------------------------------------------------------------------
// Input channel: one document byte per transaction (in_valid / in_stall),
// with in_end_of_doc high on the last byte of a document. Result channel:
// body bytes and end-of-script markers (out_valid / out_stall), with
// out_first_of_script on the first body byte of a script and out_last_of_run
// on the last result caused by one input byte.
// The opening tag is "<script" or "<SCRIPT"; the close is "</script" in any
// case. A document end closes an open script with an end marker.
// Results of a byte are registered and appear in the cycle after it is taken.
// While the receiver does not stall and each byte causes zero or one result,
// the block runs at one byte per cycle. A byte causing more than one result (a
// failed close-tag match flushing its held prefix, or a byte and an end
// marker) stalls the input while the buffer drains one entry per unstalled
// cycle; the next byte is taken in the cycle its last entry leaves.
// Reset (rst_n low, synchronous) empties the result buffer and returns the
// parser to searching for an opening tag. When the receiver stalls, the
// buffered results hold and in_stall rises once the buffer cannot empty.
// ----------------------------------------------------------------------------
`default_nettype none

module html_script_body_extractor
  import hsbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_end_of_doc,
  // result channel
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_kind,
  output      logic [7:0] out_byte_out,
  output      logic       out_first_of_script,
  output      logic       out_last_of_run
);

  // Parser state
  mode_t      mode_r, mode_nxt;
  logic [2:0] lo_r, lo_nxt;
  logic [2:0] up_r, up_nxt;
  logic [2:0] len_r, len_nxt;
  logic [7:0] held_r [HOLD_DEPTH];
  logic [7:0] held_nxt [HOLD_DEPTH];
  logic       started_r, started_nxt;

  // Result buffer, entry 0 is at the output
  rslt_t      q_r [RES_DEPTH];
  rslt_t      q_nxt [RES_DEPTH];
  logic [3:0] cnt_r, cnt_nxt;

  // Decode of the current byte
  logic       in_accept;
  logic       out_take;
  logic       flush;
  logic       tail;
  logic       single;
  logic       close_hit;
  logic       held_wr;
  logic [2:0] lo_adv;
  logic [2:0] up_adv;
  logic [3:0] nb;
  logic       marker;
  logic [7:0] seq [SEQ_DEPTH];
  rslt_t      res [RES_DEPTH];
  logic [3:0] res_cnt;

  // Handshake
  assign in_stall  = (cnt_r > 4'd1) || ((cnt_r == 4'd1) && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (cnt_r != 4'd0);
  assign out_take  = out_valid && !out_stall;

  // Byte decode: what this byte does in the current mode
  always_comb begin
    flush     = 1'b0;
    tail      = 1'b0;
    single    = 1'b0;
    close_hit = 1'b0;
    held_wr   = 1'b0;
    lo_adv    = adv_open(lo_r, open_lo_char(lo_r), in_byte_in);
    up_adv    = adv_open(up_r, open_up_char(up_r), in_byte_in);
    case (mode_r)
      MODE_BODY: begin
        single = (in_byte_in != CH_LT);
      end
      MODE_LT: begin
        if (len_r == 3'd0 && in_byte_in == CH_BANG && !started_r) begin
          flush = 1'b0;
        end else if (len_r != OPEN_DONE && fold(in_byte_in) == close_char(len_r)) begin
          if (len_r == CLOSE_LAST) begin
            close_hit = 1'b1;
          end else begin
            held_wr = 1'b1;
            // document ends inside a partial close: flush it with this byte
            flush   = in_end_of_doc;
            tail    = in_end_of_doc;
          end
        end else begin
          flush = 1'b1;
          tail  = (in_byte_in != CH_LT);
        end
      end
      MODE_BANG: begin
        single = (in_byte_in == CH_NL);
      end
      default: begin
        single = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    mode_nxt    = mode_r;
    lo_nxt      = lo_r;
    up_nxt      = up_r;
    len_nxt     = len_r;
    held_nxt    = held_r;
    started_nxt = close_hit ? 1'b0 : (started_r || nb != 4'd0);
    case (mode_r)
      MODE_OPEN: begin
        if (in_byte_in == CH_GT) mode_nxt = MODE_BODY;
      end
      MODE_BODY: begin
        if (in_byte_in == CH_LT) begin
          mode_nxt = MODE_LT;
          len_nxt  = 3'd0;
        end
      end
      MODE_LT: begin
        if (close_hit) begin
          mode_nxt = MODE_CLOSE;
          len_nxt  = 3'd0;
        end else if (held_wr) begin
          held_nxt[len_r] = in_byte_in;
          len_nxt         = len_r + 3'd1;
        end else if (flush) begin
          len_nxt  = 3'd0;
          mode_nxt = tail ? MODE_BODY : MODE_LT;
        end else begin
          mode_nxt = MODE_BANG;
        end
      end
      MODE_BANG: begin
        if (in_byte_in == CH_NL) mode_nxt = MODE_BODY;
      end
      MODE_CLOSE: begin
        if (in_byte_in == CH_GT) mode_nxt = MODE_SEARCH;
      end
      default: begin
        if (lo_adv == OPEN_DONE || up_adv == OPEN_DONE) begin
          lo_nxt   = 3'd0;
          up_nxt   = 3'd0;
          mode_nxt = MODE_OPEN;
        end else begin
          lo_nxt   = lo_adv;
          up_nxt   = up_adv;
          mode_nxt = MODE_SEARCH;
        end
      end
    endcase
    // end of document returns everything to reset
    if (in_end_of_doc) begin
      mode_nxt    = MODE_SEARCH;
      lo_nxt      = 3'd0;
      up_nxt      = 3'd0;
      len_nxt     = 3'd0;
      started_nxt = 1'b0;
    end
  end

  // Result list for this byte: emitted bytes, then an optional end marker
  always_comb begin
    if (flush) begin
      nb = 4'd1 + {1'b0, len_r} + {3'b000, tail};
    end else begin
      nb = {3'b000, single};
    end
    marker = close_hit ? started_r : (in_end_of_doc && (started_r || nb != 4'd0));
    res_cnt = nb + {3'b000, marker};

    // byte sequence: '<', held prefix, then the current byte
    seq[0] = flush ? CH_LT : in_byte_in;
    for (int j = 1; j <= int'(HOLD_DEPTH); j++) begin
      seq[j] = (3'(j - 1) < len_r) ? held_r[j - 1] : in_byte_in;
    end
    seq[SEQ_DEPTH - 1] = in_byte_in;

    for (int j = 0; j < int'(SEQ_DEPTH); j++) begin
      if (4'(j) < nb) begin
        res[j].kind  = KIND_BODY;
        res[j].data  = seq[j];
        res[j].first = (j == 0) && !started_r;
      end else begin
        res[j].kind  = (4'(j) == nb && marker) ? KIND_END : KIND_BODY;
        res[j].data  = 8'h00;
        res[j].first = 1'b0;
      end
    end
    res[RES_DEPTH - 1].kind  = (nb == 4'(SEQ_DEPTH) && marker) ? KIND_END : KIND_BODY;
    res[RES_DEPTH - 1].data  = 8'h00;
    res[RES_DEPTH - 1].first = 1'b0;
  end

  // Result buffer: load on accept, shift on take
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (in_accept) begin
      q_nxt   = res;
      cnt_nxt = res_cnt;
    end else if (out_take) begin
      for (int j = 0; j < int'(RES_DEPTH) - 1; j++) begin
        q_nxt[j] = q_r[j + 1];
      end
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SEARCH;
      lo_r      <= 3'd0;
      up_r      <= 3'd0;
      len_r     <= 3'd0;
      started_r <= 1'b0;
      cnt_r     <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_accept) begin
        mode_r    <= mode_nxt;
        lo_r      <= lo_nxt;
        up_r      <= up_nxt;
        len_r     <= len_nxt;
        started_r <= started_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (in_accept) held_r <= held_nxt;
  end

  // Output fields
  assign out_kind            = q_r[0].kind;
  assign out_byte_out        = q_r[0].data;
  assign out_first_of_script = q_r[0].first;
  assign out_last_of_run     = (cnt_r == 4'd1);

  // Assertions
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && cnt_r > 4'd1) |=> (cnt_r == $past(cnt_r) - 4'd1))
    else $error("result buffer did not drain by one entry");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind) |-> out_last_of_run)
    else $error("end marker is not the last result of its run");

  a_first_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_of_script) |-> (!out_kind && out_byte_out != CH_LT ||
                                            !out_kind))
    else $error("first-of-script flag on an end marker");

  a_eod_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_end_of_doc) |=> (mode_r == MODE_SEARCH && !started_r &&
                                      lo_r == 3'd0 && up_r == 3'd0))
    else $error("parser state not cleared after end of document");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r <= CLOSE_LAST) && (cnt_r <= 4'(RES_DEPTH)))
    else $error("close prefix length or result count out of range");

endmodule

`default_nettype wire

[sim/html_script_body_extractor_test.sv]
// ----------------------------------------------------------------------------
// HTML script body extractor testbench
// Drives HTML-like byte documents into the extractor and checks every
// emitted body byte and end-of-script marker against a local parser model.
// Runs through several idling and back-pressure phases.
// ----------------------------------------------------------------------------
`default_nettype none

module html_script_body_extractor_test;
  import hsbe_pkg::*;

  // Tag patterns, first character in the top byte
  localparam logic [55:0] OPEN_LOWER = "<script";
  localparam logic [55:0] OPEN_UPPER = "<SCRIPT";
  localparam logic [55:0] CLOSE_TAG  = "/script";

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       first;
    logic       last;
  } script_out_t;

  typedef struct {
    logic [7:0] b;
    logic       eod;
  } doc_byte_t;

  // Parser model and queue of pending script output
  class script_scoreboard;
    mode_t       mode;
    logic [2:0]  lo_cnt;
    logic [2:0]  up_cnt;
    logic [2:0]  held_len;
    logic [7:0]  held [6];
    bit          started;
    script_out_t exp_q [$];
    int          errors;

    function new();
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode     = MODE_SEARCH;
      lo_cnt   = 3'd0;
      up_cnt   = 3'd0;
      held_len = 3'd0;
      started  = 1'b0;
    endfunction

    function void add_result(kind_t k, logic [7:0] d, logic f);
      script_out_t r;
      r.kind  = k;
      r.data  = d;
      r.first = f;
      r.last  = 1'b0;
      exp_q.push_back(r);
    endfunction

    function void emit_byte(logic [7:0] b);
      add_result(KIND_BODY, b, !started);
      started = 1'b1;
    endfunction

    // Body byte: '<' starts a close-tag match, anything else goes out
    function void take_body(logic [7:0] b);
      if (b == CH_LT) begin
        mode     = MODE_LT;
        held_len = 3'd0;
      end else begin
        emit_byte(b);
      end
    endfunction

    // Failed close match: '<' and the held bytes go out as text
    function void flush_held();
      emit_byte(CH_LT);
      for (int i = 0; i < held_len; i++) begin
        emit_byte(held[i]);
      end
      held_len = 3'd0;
      mode     = MODE_BODY;
    endfunction

    function logic [2:0] step_open(logic [2:0] m, logic [55:0] pat, logic [7:0] b);
      logic [2:0] r;
      if (m < 3'd7 && b == pat[8*(6-m) +: 8]) begin
        r = m + 3'd1;
      end else if (b == CH_LT) begin
        r = 3'd1;
      end else begin
        r = 3'd0;
      end
      return r;
    endfunction

    // Predict the output caused by one accepted input transaction
    function void note_input(logic [7:0] b, logic eod);
      int          base;
      logic [7:0]  lc;
      script_out_t r;
      base = exp_q.size();
      case (mode)
        MODE_OPEN: begin
          if (b == CH_GT) mode = MODE_BODY;
        end
        MODE_BODY: begin
          take_body(b);
        end
        MODE_LT: begin
          // case-folded compare against "/script"
          lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
          if (held_len == 3'd0 && b == CH_BANG && !started) begin
            mode = MODE_BANG;
          end else if (lc == CLOSE_TAG[8*(6-held_len) +: 8]) begin
            if (held_len == 3'd6) begin
              if (started) add_result(KIND_END, 8'h00, 1'b0);
              started  = 1'b0;
              held_len = 3'd0;
              mode     = MODE_CLOSE;
            end else begin
              held[held_len] = b;
              held_len       = held_len + 3'd1;
              if (eod) flush_held();
            end
          end else begin
            flush_held();
            take_body(b);
          end
        end
        MODE_BANG: begin
          if (b == CH_NL) begin
            mode = MODE_BODY;
            emit_byte(b);
          end
        end
        MODE_CLOSE: begin
          if (b == CH_GT) mode = MODE_SEARCH;
        end
        default: begin
          lo_cnt = step_open(lo_cnt, OPEN_LOWER, b);
          up_cnt = step_open(up_cnt, OPEN_UPPER, b);
          if (lo_cnt == 3'd7 || up_cnt == 3'd7) begin
            lo_cnt = 3'd0;
            up_cnt = 3'd0;
            mode   = MODE_OPEN;
          end
        end
      endcase
      // document end closes the script and restarts the parser
      if (eod) begin
        if (started) add_result(KIND_END, 8'h00, 1'b0);
        clear_state();
      end
      if (exp_q.size() > base) begin
        r      = exp_q.pop_back();
        r.last = 1'b1;
        exp_q.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    // Compare one accepted result transaction with the oldest prediction
    function void check_result(logic k, logic [7:0] d, logic f, logic l);
      script_out_t e;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual kind %b byte %h first %b last %b",
                 $time, k, d, f, l);
        errors++;
      end else begin
        e = exp_q.pop_front();
        check_field("kind", {7'd0, e.kind}, {7'd0, k});
        check_field("byte_out", e.data, d);
        check_field("first_of_script", {7'd0, e.first}, {7'd0, f});
        check_field("last_of_run", {7'd0, e.last}, {7'd0, l});
      end
    endfunction

    function int pending();
      return exp_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_in;
  logic       in_end_of_doc;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_byte_out;
  logic       out_first_of_script;
  logic       out_last_of_run;

  script_scoreboard sb = new();
  doc_byte_t        stim_q [$];
  int               sender_idle   = 0;
  int               receiver_stall = 0;
  int               phase_no      = 0;
  int               results_seen  = 0;
  int               hold_left     = 0;
  bit               hold_done     = 1'b0;

  html_script_body_extractor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_in          (in_byte_in),
    .in_end_of_doc       (in_end_of_doc),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte_out        (out_byte_out),
    .out_first_of_script (out_first_of_script),
    .out_last_of_run     (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_byte_in, in_end_of_doc);
      if (out_valid && !out_stall) begin
        sb.check_result(out_kind, out_byte_out, out_first_of_script, out_last_of_run);
        results_seen++;
      end
    end
  end

  // Receiver: random stall, plus one long hold-off in the first phase
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (!hold_done && phase_no == 0 && results_seen >= 10) begin
        hold_done = 1'b1;
        hold_left = 120;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < receiver_stall);
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    doc_byte_t d;
    d.b   = b;
    d.eod = 1'b0;
    stim_q.push_back(d);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // Text with each lowercase letter randomly raised to uppercase
  task automatic put_cased(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1)) c = c - 8'd32;
      put_byte(c);
    end
  endtask

  task automatic put_plain(input int n);
    repeat (n) put_byte(8'($urandom_range(32, 126)));
  endtask

  task automatic end_doc();
    doc_byte_t d;
    d     = stim_q.pop_back();
    d.eod = 1'b1;
    stim_q.push_back(d);
  endtask

  // One random document: mostly well-formed scripts, some noise
  task automatic gen_doc();
    int  n_scripts;
    int  pick;
    bit  ended;
    string close_s;
    close_s   = "/script";
    ended     = 1'b0;
    n_scripts = $urandom_range(1, 3);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(5, 20)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      for (int s = 0; s < n_scripts && !ended; s++) begin
        // leading text, sometimes with a broken opening tag
        put_plain($urandom_range(0, 3));
        pick = $urandom_range(5);
        if (pick == 0) put_text("<scr");
        else if (pick == 1) put_text("<<S");
        // opening tag, occasionally with mixed spelling
        pick = $urandom_range(9);
        if (pick == 0) put_text("<Script");
        else if (pick <= 5) put_text("<script");
        else put_text("<SCRIPT");
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(97, 122)));
        if ($urandom_range(15) == 0) begin
          // opening tag never closed
          ended = 1'b1;
        end else begin
          put_byte(CH_GT);
          if ($urandom_range(3) == 0) begin
            put_text("<!");
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(11, 255)));
            put_byte(CH_NL);
          end
          if ($urandom_range(7) != 0) begin
            repeat ($urandom_range(1, 6)) begin
              case ($urandom_range(5))
                0, 1: put_plain($urandom_range(1, 4));
                2: put_byte(8'($urandom_range(0, 255)));
                3: begin
                  put_byte(CH_LT);
                  put_cased(close_s.substr(0, $urandom_range(0, 5)));
                  put_byte(8'($urandom_range(32, 126)));
                end
                4: put_text("<!");
                default: begin
                  put_byte(CH_LT);
                  put_byte(($urandom_range(1)) ? CH_LT : CH_NL);
                end
              endcase
            end
          end
          pick = $urandom_range(7);
          if (pick == 0) begin
            put_byte(CH_LT);
            ended = 1'b1;
          end else if (pick == 1) begin
            put_byte(CH_LT);
            put_cased(close_s.substr(0, $urandom_range(0, 5)));
            ended = 1'b1;
          end else begin
            put_byte(CH_LT);
            put_cased(close_s);
            put_plain($urandom_range(0, 2));
            put_byte(CH_GT);
          end
        end
      end
      if (!ended) put_plain($urandom_range(1, 3));
    end
    end_doc();
  endtask

  // Offer one input transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eod);
    while ($urandom_range(99) < sender_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_byte_in    = b;
    in_end_of_doc = eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    doc_byte_t d;
    sender_idle    = idle;
    receiver_stall = stall;
    while (stim_q.size() < count) gen_doc();
    while (stim_q.size() > 0) begin
      d = stim_q.pop_front();
      send_byte(d.b, d.eod);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_in    = 8'h00;
    in_end_of_doc = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: uppercase open, comment line, byte extremes, failed close,
    // partial close flushed at document end
    put_text("<SCRIPT>");
    put_text("<!q");
    put_byte(CH_NL);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_text("</sX");
    put_text("</Sc");
    end_doc();

    phase_no = 0;
    run_phase(0, 0, 50);
    phase_no = 1;
    run_phase(75, 0, 45);
    phase_no = 2;
    run_phase(0, 75, 45);
    phase_no = 3;
    run_phase(31, 31, 45);
    in_valid = 1'b0;

    // drain, then give stray results time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
